FILE: sv/hss_pkg.sv
package hss_pkg;

	// Session modes, as reported on session_mode
	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_HEATING  = 3'd1,
		MODE_READY    = 3'd2,
		MODE_ACTIVE   = 3'd3,
		MODE_COOLDOWN = 3'd4,
		MODE_FAULT    = 3'd5
	} mode_t;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic REG_READY_MARGIN  = 1'b0;
	localparam logic REG_COOLDOWN_TEMP = 1'b1;

	localparam int TEMP_W   = 15;
	localparam int TIME_W   = 32;
	localparam int MARGIN_W = 10;
	localparam int CFG_W    = 15;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 10'd50;
	localparam logic signed [TEMP_W-1:0] COOL_RESET = 15'sd1500;

endpackage

FILE: sv/heater_session_sequencer.sv
// Each accepted item passes through the input register, then the result register,
// where it is offered until taken. Throughput: one item per cycle while out_stall
// is low; the session state is updated in the same cycle the item moves from the
// input register to the result register.
// Reset (arst_n low, asynchronous): mode idle, heater off, times and
// temperatures 0, ready_margin 50, cooldown_temp 1500, no item held.
module heater_session_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [hss_pkg::CFG_W-1:0]    cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   operation,
	input  logic [hss_pkg::TIME_W-1:0]   time_ms,
	input  logic signed [hss_pkg::TEMP_W-1:0] temperature,
	input  logic                         safety_fault,
	input  logic                         draw_started,
	input  logic                         draw_ended,
	input  logic                         hit_allowed,
	input  logic                         battery_locked_out,
	input  logic                         atomizer_present,
	input  logic signed [hss_pkg::TEMP_W-1:0] profile_start_temp,
	input  logic [hss_pkg::TIME_W-1:0]   profile_hold_ms,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   session_mode,
	output logic                         heater_on,
	output logic                         hit_counted,
	output logic                         session_done,
	output logic [hss_pkg::TIME_W-1:0]   session_duration_ms,
	output logic signed [hss_pkg::TEMP_W-1:0] session_peak_temp,
	output logic [hss_pkg::TIME_W-1:0]   hold_elapsed_ms
);
	import hss_pkg::*;

	// configuration registers
	logic [MARGIN_W-1:0]      ready_margin_q;
	logic signed [TEMP_W-1:0] cooldown_temp_q;

	// input register
	logic                     valid_s1;
	op_t                      op_s1;
	logic [TIME_W-1:0]        now_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     fault_s1, dstart_s1, dend_s1, hit_ok_s1, locked_s1, atom_s1;
	logic signed [TEMP_W-1:0] p_start_s1;
	logic [TIME_W-1:0]        p_hold_s1;

	// session state
	mode_t                    mode_q;
	logic [TIME_W-1:0]        entry_q;
	logic signed [TEMP_W-1:0] peak_q;
	logic signed [TEMP_W-1:0] target_q;
	logic [TIME_W-1:0]        hold_win_q;
	logic                     heater_q;

	// next state
	mode_t                    mode_d;
	logic [TIME_W-1:0]        entry_d;
	logic signed [TEMP_W-1:0] peak_d;
	logic signed [TEMP_W-1:0] target_d;
	logic [TIME_W-1:0]        hold_win_d;
	logic                     heater_d;
	logic                     hit_d;
	logic                     done_d;
	logic                     do_stop;

	// result values
	logic [TIME_W-1:0]        duration_d;
	logic [TIME_W-1:0]        hold_el_d;

	// result register
	logic                     out_valid_q;
	mode_t                    mode_out_q;
	logic                     heater_out_q, hit_out_q, done_out_q;
	logic [TIME_W-1:0]        duration_q, hold_el_q;
	logic signed [TEMP_W-1:0] peak_out_q;

	logic                     advance, fire, accept;
	logic signed [TEMP_W+1:0] ready_thr;
	logic [TIME_W-1:0]        held;

	// handshake
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_margin_q  <= MARGIN_RESET;
			cooldown_temp_q <= COOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_READY_MARGIN:  ready_margin_q  <= cfg_data[MARGIN_W-1:0];
				REG_COOLDOWN_TEMP: cooldown_temp_q <= $signed(cfg_data[TEMP_W-1:0]);
				default:           ready_margin_q  <= ready_margin_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(operation);
			now_s1     <= time_ms;
			temp_s1    <= temperature;
			fault_s1   <= safety_fault;
			dstart_s1  <= draw_started;
			dend_s1    <= draw_ended;
			hit_ok_s1  <= hit_allowed;
			locked_s1  <= battery_locked_out;
			atom_s1    <= atomizer_present;
			p_start_s1 <= profile_start_temp;
			p_hold_s1  <= profile_hold_ms;
		end
	end

	// ready threshold: start temperature less margin, two bits of headroom
	assign ready_thr = {{2{target_q[TEMP_W-1]}}, target_q}
		- $signed({2'b00, {(TEMP_W-MARGIN_W){1'b0}}, ready_margin_q});
	assign held = now_s1 - entry_q;

	// next state
	always_comb begin
		mode_d     = mode_q;
		entry_d    = entry_q;
		peak_d     = peak_q;
		target_d   = target_q;
		hold_win_d = hold_win_q;
		heater_d   = heater_q;
		hit_d      = 1'b0;
		done_d     = 1'b0;
		do_stop    = 1'b0;
		unique case (op_s1)
			OP_TICK: begin
				if (temp_s1 > peak_q)
					peak_d = temp_s1;
				if ((mode_q == MODE_HEATING || mode_q == MODE_READY
						|| mode_q == MODE_ACTIVE) && fault_s1) begin
					heater_d = 1'b0;
					mode_d   = MODE_FAULT;
					entry_d  = now_s1;
				end else begin
					unique case (mode_q)
						MODE_HEATING: begin
							if ($signed({{2{temp_s1[TEMP_W-1]}}, temp_s1}) >= ready_thr) begin
								mode_d  = MODE_READY;
								entry_d = now_s1;
							end
						end
						MODE_READY: begin
							if (dstart_s1 && hit_ok_s1) begin
								hit_d   = 1'b1;
								mode_d  = MODE_ACTIVE;
								entry_d = now_s1;
							end else if (held >= hold_win_q) begin
								do_stop = 1'b1;
							end
						end
						MODE_ACTIVE: begin
							if (dend_s1) begin
								mode_d  = MODE_READY;
								entry_d = now_s1;
							end
						end
						MODE_COOLDOWN: begin
							if (temp_s1 <= cooldown_temp_q) begin
								mode_d  = MODE_IDLE;
								entry_d = now_s1;
							end
						end
						default: ;
					endcase
				end
			end
			OP_START: begin
				if (mode_q == MODE_IDLE && !locked_s1 && atom_s1) begin
					target_d   = p_start_s1;
					hold_win_d = p_hold_s1;
					peak_d     = temp_s1;
					heater_d   = 1'b1;
					mode_d     = MODE_HEATING;
					entry_d    = now_s1;
				end
			end
			OP_STOP: do_stop = 1'b1;
			default: begin
				if (mode_q == MODE_FAULT) begin
					mode_d  = MODE_IDLE;
					entry_d = now_s1;
				end
			end
		endcase
		// stop: outside idle and fault, do_stop moves the mode to cooldown with the heater off
		if (do_stop && mode_q != MODE_IDLE && mode_q != MODE_FAULT) begin
			done_d   = (mode_q == MODE_READY || mode_q == MODE_ACTIVE);
			heater_d = 1'b0;
			mode_d   = MODE_COOLDOWN;
			entry_d  = now_s1;
		end
	end

	// result values
	always_comb begin
		duration_d = done_d ? held : '0;
		hold_el_d  = (mode_d == MODE_READY || mode_d == MODE_ACTIVE)
			? (now_s1 - entry_d) : '0;
	end

	// session state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			entry_q    <= '0;
			peak_q     <= '0;
			target_q   <= '0;
			hold_win_q <= '0;
			heater_q   <= 1'b0;
		end else if (fire) begin
			mode_q     <= mode_d;
			entry_q    <= entry_d;
			peak_q     <= peak_d;
			target_q   <= target_d;
			hold_win_q <= hold_win_d;
			heater_q   <= heater_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mode_out_q   <= mode_d;
			heater_out_q <= heater_d;
			hit_out_q    <= hit_d;
			done_out_q   <= done_d;
			duration_q   <= duration_d;
			peak_out_q   <= peak_d;
			hold_el_q    <= hold_el_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign session_mode        = mode_out_q;
	assign heater_on           = heater_out_q;
	assign hit_counted         = hit_out_q;
	assign session_done        = done_out_q;
	assign session_duration_ms = duration_q;
	assign session_peak_temp   = peak_out_q;
	assign hold_elapsed_ms     = hold_el_q;

endmodule

FILE: sv/hss_checker.sv
module hss_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [2:0]                   session_mode,
	input logic                         heater_on,
	input logic                         hit_counted,
	input logic                         session_done,
	input logic [hss_pkg::TIME_W-1:0]   session_duration_ms
);
	import hss_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a counted hit always lands in active draw
	a_hit_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_counted |-> session_mode == MODE_ACTIVE)
		else $error("hit counted outside active mode");

	// a recorded session ends in cooldown with the heater off
	a_done_cool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && session_done |-> session_mode == MODE_COOLDOWN && !heater_on)
		else $error("session recorded without entering cooldown");

	// duration is only reported with a recorded session
	a_dur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !session_done |-> session_duration_ms == '0)
		else $error("duration reported without a session");

	// heater runs exactly in heating, ready and active
	a_heater_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heater_on == (session_mode == MODE_HEATING
			|| session_mode == MODE_READY || session_mode == MODE_ACTIVE))
		else $error("heater state disagrees with mode");

endmodule

bind heater_session_sequencer hss_checker u_hss_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_valid),
	.out_stall           (out_stall),
	.session_mode        (session_mode),
	.heater_on           (heater_on),
	.hit_counted         (hit_counted),
	.session_done        (session_done),
	.session_duration_ms (session_duration_ms)
);

FILE: verif/heater_session_sequencer_tb.sv
`timescale 1ns / 100ps

module heater_session_sequencer_tb;
	import hss_pkg::*;

	// One input item as offered on the input channel
	typedef struct packed {
		op_t                op;
		logic [31:0]        t;
		logic signed [14:0] temp;
		logic               fault;
		logic               dstart;
		logic               dend;
		logic               hit_ok;
		logic               locked;
		logic               atom;
		logic signed [14:0] pstart;
		logic [31:0]        phold;
	} item_t;

	// One session report as seen on the output channel
	typedef struct packed {
		mode_t              mode;
		logic               heater;
		logic               hit;
		logic               done;
		logic [31:0]        dur;
		logic signed [14:0] peak;
		logic [31:0]        hold;
	} result_t;

	// Flag bits for building directed rows: {fault, dstart, dend, hit_ok, locked, atom}
	localparam logic [5:0] FL_FAULT  = 6'b100000;
	localparam logic [5:0] FL_DSTART = 6'b010000;
	localparam logic [5:0] FL_DEND   = 6'b001000;
	localparam logic [5:0] FL_HITOK  = 6'b000100;
	localparam logic [5:0] FL_LOCK   = 6'b000010;
	localparam logic [5:0] FL_ATOM   = 6'b000001;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [TIME_W-1:0]  time_ms;
	logic signed [TEMP_W-1:0] temperature;
	logic               safety_fault;
	logic               draw_started;
	logic               draw_ended;
	logic               hit_allowed;
	logic               battery_locked_out;
	logic               atomizer_present;
	logic signed [TEMP_W-1:0] profile_start_temp;
	logic [TIME_W-1:0]  profile_hold_ms;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         session_mode;
	logic               heater_on;
	logic               hit_counted;
	logic               session_done;
	logic [TIME_W-1:0]  session_duration_ms;
	logic signed [TEMP_W-1:0] session_peak_temp;
	logic [TIME_W-1:0]  hold_elapsed_ms;

	heater_session_sequencer DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.operation           (operation),
		.time_ms             (time_ms),
		.temperature         (temperature),
		.safety_fault        (safety_fault),
		.draw_started        (draw_started),
		.draw_ended          (draw_ended),
		.hit_allowed         (hit_allowed),
		.battery_locked_out  (battery_locked_out),
		.atomizer_present    (atomizer_present),
		.profile_start_temp  (profile_start_temp),
		.profile_hold_ms     (profile_hold_ms),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.session_mode        (session_mode),
		.heater_on           (heater_on),
		.hit_counted         (hit_counted),
		.session_done        (session_done),
		.session_duration_ms (session_duration_ms),
		.session_peak_temp   (session_peak_temp),
		.hold_elapsed_ms     (hold_elapsed_ms)
	);

	// Shadow session state and register copies
	mode_t       st_mode;
	logic [31:0] st_entry;
	int          st_peak;
	int          st_target;
	logic [31:0] st_hold;
	bit          st_heater;
	int          cfg_margin;
	int          cfg_cool;

	result_t     pending_results[$];
	result_t     oldest;
	bit          failed;
	int          gap_pct;
	int          stall_pct;
	logic [31:0] clock_ms;

	item_t       dir_items[$];
	bit          dir_chk[$];
	result_t     dir_res[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : timeout_guard
		#5_000_000;
		$display("heater_session_sequencer_tb NOT OK");
		$finish;
	end

	task automatic enter_mode(input mode_t m, input logic [31:0] now);
		st_mode  = m;
		st_entry = now;
	endtask

	// Advance the shadow session by one item and work out its report
	task automatic advance_session(input item_t it, output result_t r);
		int          tmp;
		logic [31:0] now;
		bit          stop_req;
		tmp      = it.temp;
		now      = it.t;
		stop_req = 1'b0;
		r        = '0;
		case (it.op)
			OP_TICK: begin
				if (tmp > st_peak)
					st_peak = tmp;
				if (it.fault && (st_mode == MODE_HEATING || st_mode == MODE_READY ||
						st_mode == MODE_ACTIVE)) begin
					st_heater = 1'b0;
					enter_mode(MODE_FAULT, now);
				end else begin
					case (st_mode)
						MODE_HEATING: begin
							if (tmp >= st_target - cfg_margin)
								enter_mode(MODE_READY, now);
						end
						MODE_READY: begin
							if (it.dstart && it.hit_ok) begin
								r.hit = 1'b1;
								enter_mode(MODE_ACTIVE, now);
							end else if (now - st_entry >= st_hold) begin
								stop_req = 1'b1;
							end
						end
						MODE_ACTIVE: begin
							if (it.dend)
								enter_mode(MODE_READY, now);
						end
						MODE_COOLDOWN: begin
							if (tmp <= cfg_cool)
								enter_mode(MODE_IDLE, now);
						end
						default: ;
					endcase
				end
			end
			OP_START: begin
				if (st_mode == MODE_IDLE && !it.locked && it.atom) begin
					st_target = it.pstart;
					st_hold   = it.phold;
					st_peak   = tmp;
					st_heater = 1'b1;
					enter_mode(MODE_HEATING, now);
				end
			end
			OP_STOP: stop_req = 1'b1;
			default: begin
				if (st_mode == MODE_FAULT)
					enter_mode(MODE_IDLE, now);
			end
		endcase
		// stop handling, shared by a stop request and the hold timeout
		if (stop_req && st_mode != MODE_IDLE && st_mode != MODE_FAULT) begin
			if (st_mode == MODE_READY || st_mode == MODE_ACTIVE) begin
				r.done = 1'b1;
				r.dur  = now - st_entry;
			end
			st_heater = 1'b0;
			enter_mode(MODE_COOLDOWN, now);
		end
		r.mode   = st_mode;
		r.heater = st_heater;
		r.peak   = st_peak[14:0];
		r.hold   = (st_mode == MODE_READY || st_mode == MODE_ACTIVE) ? now - st_entry : 32'd0;
	endtask

	function automatic item_t mk_item(input op_t op, input logic [31:0] t, input int temp,
			input logic [5:0] fl, input int ps, input logic [31:0] ph);
		item_t it;
		it.op     = op;
		it.t      = t;
		it.temp   = temp[14:0];
		{it.fault, it.dstart, it.dend, it.hit_ok, it.locked, it.atom} = fl;
		it.pstart = ps[14:0];
		it.phold  = ph;
		return it;
	endfunction

	function automatic result_t mk_res(input mode_t m, input logic h, input logic hit,
			input logic d, input logic [31:0] dur, input int peak, input logic [31:0] hold);
		result_t r;
		r.mode   = m;
		r.heater = h;
		r.hit    = hit;
		r.done   = d;
		r.dur    = dur;
		r.peak   = peak[14:0];
		r.hold   = hold;
		return r;
	endfunction

	task automatic add_row(input item_t it, input bit chk, input result_t r);
		dir_items.push_back(it);
		dir_chk.push_back(chk);
		dir_res.push_back(r);
	endtask

	function automatic int clamp_temp(input int v);
		if (v < -400)
			return -400;
		if (v > 10000)
			return 10000;
		return v;
	endfunction

	function automatic int rand_temp();
		return int'($urandom_range(10400)) - 400;
	endfunction

	// Offer one item, with random idle cycles ahead of it, and record its report
	task automatic offer_item(input item_t it, input bit chk, input result_t typed);
		result_t r;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation          <= it.op;
		time_ms            <= it.t;
		temperature        <= it.temp;
		safety_fault       <= it.fault;
		draw_started       <= it.dstart;
		draw_ended         <= it.dend;
		hit_allowed        <= it.hit_ok;
		battery_locked_out <= it.locked;
		atomizer_present   <= it.atom;
		profile_start_temp <= it.pstart;
		profile_hold_ms    <= it.phold;
		in_valid           <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_session(it, r);
		pending_results.push_back(chk ? typed : r);
	endtask

	// Mostly well-formed session traffic, steered by the shadow mode
	task automatic next_session_item(output item_t it);
		int roll;
		roll = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(400);
		if ($urandom_range(49) == 0)
			clock_ms = $urandom();
		it.op     = OP_TICK;
		it.t      = clock_ms;
		it.temp   = 15'(rand_temp());
		it.fault  = ($urandom_range(99) < 3);
		it.dstart = 1'b0;
		it.dend   = 1'b0;
		it.hit_ok = ($urandom_range(9) != 0);
		it.locked = ($urandom_range(9) == 0);
		it.atom   = ($urandom_range(9) != 0);
		it.pstart = 15'(rand_temp());
		it.phold  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(3000);
		if (roll < 10) begin
			// noise: any operation, any flags
			it.op = op_t'($urandom_range(3));
			{it.fault, it.dstart, it.dend, it.hit_ok, it.locked, it.atom} =
				6'($urandom_range(63));
		end else begin
			case (st_mode)
				MODE_IDLE: begin
					if (roll < 80)
						it.op = OP_START;
				end
				MODE_HEATING: begin
					it.temp = 15'(clamp_temp(st_target - cfg_margin - 150
						+ int'($urandom_range(250))));
					if (roll >= 94)
						it.op = OP_STOP;
					else if (roll >= 88)
						it.op = OP_START;
				end
				MODE_READY: begin
					it.dstart = ($urandom_range(3) == 0);
					if (roll >= 90)
						it.op = OP_STOP;
				end
				MODE_ACTIVE: begin
					it.dend = ($urandom_range(2) == 0);
					if (roll >= 90)
						it.op = OP_STOP;
				end
				MODE_COOLDOWN: begin
					it.temp = 15'(clamp_temp(cfg_cool - 150 + int'($urandom_range(250))));
					if (roll >= 95)
						it.op = OP_STOP;
				end
				default: begin
					if (roll < 60)
						it.op = OP_ACK;
					else if (roll < 75)
						it.op = op_t'($urandom_range(2));
				end
			endcase
		end
	endtask

	// Let every expected report arrive and the pipeline empty
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_READY_MARGIN)
			cfg_margin = int'(val[MARGIN_W-1:0]);
		else
			cfg_cool = int'(signed'(val));
	endtask

	task automatic run_phase(input int gap, input int stall, input int margin, input int cool,
			input int n);
		item_t it;
		drain();
		write_reg(REG_READY_MARGIN, CFG_W'(margin));
		write_reg(REG_COOLDOWN_TEMP, CFG_W'(cool));
		gap_pct   = gap;
		stall_pct = stall;
		repeat (n) begin
			next_session_item(it);
			offer_item(it, 1'b0, '0);
		end
	endtask

	// Receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare each accepted report with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("session report with nothing expected");
				failed = 1'b1;
			end else begin
				oldest = pending_results.pop_front();
				if (session_mode !== oldest.mode) begin
					$error("session_mode: expected %0d, got %0d", oldest.mode, session_mode);
					failed = 1'b1;
				end
				if (heater_on !== oldest.heater) begin
					$error("heater_on: expected %0d, got %0d", oldest.heater, heater_on);
					failed = 1'b1;
				end
				if (hit_counted !== oldest.hit) begin
					$error("hit_counted: expected %0d, got %0d", oldest.hit, hit_counted);
					failed = 1'b1;
				end
				if (session_done !== oldest.done) begin
					$error("session_done: expected %0d, got %0d", oldest.done, session_done);
					failed = 1'b1;
				end
				if (session_duration_ms !== oldest.dur) begin
					$error("session_duration_ms: expected %0d, got %0d", oldest.dur,
						session_duration_ms);
					failed = 1'b1;
				end
				if (session_peak_temp !== oldest.peak) begin
					$error("session_peak_temp: expected %0d, got %0d", oldest.peak,
						session_peak_temp);
					failed = 1'b1;
				end
				if (hold_elapsed_ms !== oldest.hold) begin
					$error("hold_elapsed_ms: expected %0d, got %0d", oldest.hold,
						hold_elapsed_ms);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = 1'b0;
		cfg_data           = '0;
		in_valid           = 1'b0;
		out_stall          = 1'b0;
		operation          = OP_TICK;
		time_ms            = '0;
		temperature        = '0;
		safety_fault       = 1'b0;
		draw_started       = 1'b0;
		draw_ended         = 1'b0;
		hit_allowed        = 1'b0;
		battery_locked_out = 1'b0;
		atomizer_present   = 1'b0;
		profile_start_temp = '0;
		profile_hold_ms    = '0;
		failed             = 1'b0;
		gap_pct            = 0;
		stall_pct          = 0;
		clock_ms           = 32'hFFFF_F000;
		st_mode            = MODE_IDLE;
		st_entry           = '0;
		st_peak            = 0;
		st_target          = 0;
		st_hold            = '0;
		st_heater          = 1'b0;
		cfg_margin         = int'(MARGIN_RESET);
		cfg_cool           = int'(COOL_RESET);

		// Directed rows, with register values as after reset
		add_row(mk_item(OP_TICK, 0, 0, 0, 0, 0), 1,
			mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));
		// stop while idle is ignored
		add_row(mk_item(OP_STOP, 1, 0, 0, 0, 0), 1,
			mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));
		// acknowledge outside fault is ignored
		add_row(mk_item(OP_ACK, 2, 0, 0, 0, 0), 1,
			mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));
		// start refused under lockout, then without an atomizer
		add_row(mk_item(OP_START, 3, 0, FL_LOCK | FL_ATOM, 100, 10), 1,
			mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));
		add_row(mk_item(OP_START, 4, 0, 0, 100, 10), 1,
			mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));
		// accepted start at the field extremes
		add_row(mk_item(OP_START, 100, -400, FL_ATOM, 10000, 32'hFFFF_FFFF), 1,
			mk_res(MODE_HEATING, 1, 0, 0, 0, -400, 0));
		// start outside idle refused; non-tick leaves the peak alone
		add_row(mk_item(OP_START, 150, 5000, FL_ATOM, 0, 0), 1,
			mk_res(MODE_HEATING, 1, 0, 0, 0, -400, 0));
		// one short of ready, then exactly at the margin
		add_row(mk_item(OP_TICK, 200, 9949, 0, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 300, 9950, 0, 0, 0), 0, '0);
		// time wraps past zero while ready
		add_row(mk_item(OP_TICK, 16, 10000, 0, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 20, 0, FL_DSTART, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 30, 0, FL_DSTART | FL_HITOK, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 40, 0, FL_DEND, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 50, 0, FL_DSTART | FL_HITOK, 0, 0), 0, '0);
		// stop from active records the session
		add_row(mk_item(OP_STOP, 60, 0, 0, 0, 0), 0, '0);
		// stop from cooldown re-enters cooldown
		add_row(mk_item(OP_STOP, 70, 0, 0, 0, 0), 0, '0);
		// safety fault is not honoured in cooldown
		add_row(mk_item(OP_TICK, 80, 1501, FL_FAULT, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 90, 1500, 0, 0, 0), 0, '0);
		add_row(mk_item(OP_START, 100, 10000, FL_ATOM, -400, 0), 0, '0);
		add_row(mk_item(OP_TICK, 110, -400, 0, 0, 0), 0, '0);
		// zero hold window times out on the first ready tick
		add_row(mk_item(OP_TICK, 120, -400, 0, 0, 0), 0, '0);
		add_row(mk_item(OP_TICK, 130, -400, 0, 0, 0), 0, '0);
		add_row(mk_item(OP_START, 140, 0, FL_ATOM, 0, 5), 0, '0);
		add_row(mk_item(OP_TICK, 150, 0, FL_FAULT, 0, 0), 1,
			mk_res(MODE_FAULT, 0, 0, 0, 0, 0, 0));
		add_row(mk_item(OP_ACK, 160, 0, 0, 0, 0), 1,
			mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_items[i])
			offer_item(dir_items[i], dir_chk[i], dir_res[i]);

		// Random phases over several register settings and idling patterns
		run_phase(0, 0, 1000, 10000, 150);
		run_phase(62, 0, 0, -400, 200);
		run_phase(0, 62, 50, 1500, 200);
		run_phase(27, 27, $urandom_range(1000), rand_temp(), 200);
		run_phase(0, 0, $urandom_range(1000), rand_temp(), 200);
		run_phase(27, 27, 1000, -400, 200);

		drain();
		if (!failed)
			$display("heater_session_sequencer_tb OK");
		else
			$display("heater_session_sequencer_tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
sv/hss_pkg.sv
sv/heater_session_sequencer.sv
sv/hss_checker.sv
verif/heater_session_sequencer_tb.sv
